// ----- sv/i2c_srb_pkg.sv -----
package i2c_srb_pkg;

    localparam int RegCountDefault = 18;

    // registers that can ever hold a non-zero value
    localparam int CtrlReg   = 1;
    localparam int StoreLast = 11;
    localparam int AdcSlots  = 10;

    localparam logic [7:0] MaskReset = 8'hff;

    typedef enum logic [1:0] {
        OP_ADDR  = 2'd0,
        OP_DATA  = 2'd1,
        OP_ADC   = 2'd2,
        OP_CLEAR = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        PHASE_IDLE = 2'd0,
        PHASE_ADDR = 2'd1,
        PHASE_DATA = 2'd2
    } phase_t;

    // apb register indexes
    localparam logic REG_IDX_MASK = 1'b0;

    // adc scan slot to register index
    function automatic logic [3:0] adc_reg(input logic [3:0] slot);
        logic [3:0] r;
        case (slot)
            4'd0:    r = 4'd3;
            4'd1:    r = 4'd4;
            4'd2:    r = 4'd5;
            4'd3:    r = 4'd6;
            4'd4:    r = 4'd2;
            4'd5:    r = 4'd11;
            4'd6:    r = 4'd7;
            4'd7:    r = 4'd8;
            4'd8:    r = 4'd9;
            4'd9:    r = 4'd10;
            default: r = 4'd0;
        endcase
        return r;
    endfunction

endpackage

// ----- sv/i2c_slave_register_bank.sv -----
// an accepted item is loaded into the input register, and its result then
// into the result register once the result side can take it
// throughput: one item per cycle while the result side keeps taking items
// aresetn (synchronous, active low) clears the register store, the control
// changed flag, the pointer and the phase, and sets the write mask to all ones
module i2c_slave_register_bank #(
    parameter int REG_COUNT = i2c_srb_pkg::RegCountDefault
) (
    input  logic        aclk,
    input  logic        aresetn,
    // s_tdata: read_dir, bus_byte[7:0], adc_slot[3:0], adc_value[7:0]
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,
    // s_tuser: op[1:0]
    input  logic [1:0]  s_tuser,
    // m_tdata: tx_valid, tx_byte[7:0], control_changed, bus_phase[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int PtrW   = $clog2(REG_COUNT);
    localparam int StoreN = i2c_srb_pkg::StoreLast;

    // input register
    logic                 in_valid_reg;
    i2c_srb_pkg::op_t     in_op_reg;
    logic                 in_rd_reg;
    logic [7:0]           in_byte_reg;
    logic [3:0]           in_slot_reg;
    logic [7:0]           in_sample_reg;

    // state
    logic [7:0]           store_reg [1:StoreN];
    logic [7:0]           store_next [1:StoreN];
    logic [PtrW-1:0]      ptr_reg, ptr_next;
    i2c_srb_pkg::phase_t  phase_reg, phase_next;
    logic                 ctl_changed_reg, ctl_changed_next;
    logic [7:0]           mask_reg;

    // result register
    logic                 out_valid_reg;
    logic                 out_tx_valid_reg, out_tx_valid_next;
    logic [7:0]           out_tx_byte_reg, out_tx_byte_next;

    logic                 out_adv;
    logic                 fire;
    logic [PtrW-1:0]      ptr_inc;
    logic [3:0]           adc_idx;

    function automatic logic [7:0] read_reg(input logic [PtrW-1:0] idx,
                                            input logic [7:0] st [1:StoreN]);
        logic [7:0] v;
        v = 8'h00;
        for (int i = 1; i <= StoreN; i++) begin
            if (idx == PtrW'(i)) begin
                v = st[i];
            end
        end
        return v;
    endfunction

    assign out_adv  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || out_adv;
    assign fire     = in_valid_reg && out_adv;

    assign ptr_inc = (ptr_reg == PtrW'(REG_COUNT - 1)) ? '0 : ptr_reg + PtrW'(1);
    assign adc_idx = i2c_srb_pkg::adc_reg(in_slot_reg);

    always_comb begin
        store_next        = store_reg;
        ptr_next          = ptr_reg;
        phase_next        = phase_reg;
        ctl_changed_next  = ctl_changed_reg;
        out_tx_valid_next = 1'b0;
        out_tx_byte_next  = 8'h00;
        case (in_op_reg)
            i2c_srb_pkg::OP_ADDR: begin
                if (in_rd_reg) begin
                    out_tx_valid_next = 1'b1;
                    out_tx_byte_next  = read_reg(ptr_reg, store_reg);
                end else begin
                    phase_next = i2c_srb_pkg::PHASE_ADDR;
                end
            end
            i2c_srb_pkg::OP_DATA: begin
                if (in_rd_reg) begin
                    ptr_next          = ptr_inc;
                    out_tx_valid_next = 1'b1;
                    out_tx_byte_next  = read_reg(ptr_inc, store_reg);
                end else if (phase_reg == i2c_srb_pkg::PHASE_ADDR) begin
                    ptr_next   = ({1'b0, in_byte_reg} >= 9'(REG_COUNT)) ? '0
                                 : PtrW'(in_byte_reg);
                    phase_next = i2c_srb_pkg::PHASE_DATA;
                end else if (phase_reg == i2c_srb_pkg::PHASE_DATA) begin
                    // only the control register takes bus writes
                    if (ptr_reg == PtrW'(i2c_srb_pkg::CtrlReg)) begin
                        store_next[i2c_srb_pkg::CtrlReg] =
                            (in_byte_reg & mask_reg) |
                            (store_reg[i2c_srb_pkg::CtrlReg] & ~mask_reg);
                        ctl_changed_next = 1'b1;
                    end
                    ptr_next = ptr_inc;
                end
            end
            i2c_srb_pkg::OP_ADC: begin
                if (in_slot_reg < 4'(i2c_srb_pkg::AdcSlots)) begin
                    for (int i = 1; i <= StoreN; i++) begin
                        if (adc_idx == 4'(i)) begin
                            store_next[i] = in_sample_reg;
                        end
                    end
                end
            end
            default: begin
                ctl_changed_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            ptr_reg         <= '0;
            phase_reg       <= i2c_srb_pkg::PHASE_IDLE;
            ctl_changed_reg <= 1'b0;
            mask_reg        <= i2c_srb_pkg::MaskReset;
            for (int i = 1; i <= StoreN; i++) begin
                store_reg[i] <= 8'h00;
            end
        end else begin
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (fire) begin
                in_valid_reg <= 1'b0;
            end
            if (fire) begin
                out_valid_reg   <= 1'b1;
                ptr_reg         <= ptr_next;
                phase_reg       <= phase_next;
                ctl_changed_reg <= ctl_changed_next;
                store_reg       <= store_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (psel && penable && pwrite && pready
                && paddr[2] == i2c_srb_pkg::REG_IDX_MASK) begin
                mask_reg <= pwdata[7:0];
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_op_reg     <= i2c_srb_pkg::op_t'(s_tuser);
            in_rd_reg     <= s_tdata[0];
            in_byte_reg   <= s_tdata[8:1];
            in_slot_reg   <= s_tdata[12:9];
            in_sample_reg <= s_tdata[20:13];
        end
        if (fire) begin
            out_tx_valid_reg <= out_tx_valid_next;
            out_tx_byte_reg  <= out_tx_byte_next;
        end
    end

    // flag and phase in the result are the state after the item
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, phase_reg, ctl_changed_reg, out_tx_byte_reg, out_tx_valid_reg};

    assign pready = 1'b1;
    assign prdata = (paddr[2] == i2c_srb_pkg::REG_IDX_MASK) ? {24'h000000, mask_reg}
                                                          : 32'h00000000;

endmodule

// ----- sv/i2c_srb_checker.sv -----
module i2c_srb_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    // no result straight after reset
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // no byte is sent unless flagged
    a_tx_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[0] |-> m_tdata[8:1] == 8'h00)
        else $error("tx byte set without tx valid");

    // with nothing waiting on the result side the input is open
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input blocked while result side empty");

endmodule

bind i2c_slave_register_bank i2c_srb_checker u_i2c_srb_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
